>>> sv/alt_pkg.sv
`default_nettype none
package alt_pkg;

  localparam int unsigned LEDGER_DEPTH_DEF = 1024;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned SEQ_W  = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_SNAP   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DOUBLE  = 3'd1,
    ST_WILD    = 3'd2,
    ST_FULL    = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              active;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } entry_t;

endpackage
`default_nettype wire

>>> sv/alt_ledger_ram.sv
`default_nettype none
module alt_ledger_ram #(
  parameter int unsigned DEPTH = alt_pkg::LEDGER_DEPTH_DEF,
  parameter int unsigned AW    = 10
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  alt_pkg::entry_t     wdata_i,
  input  wire logic [AW-1:0]  raddr_i,
  output alt_pkg::entry_t     rdata_o
);
  import alt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/allocation_ledger_tracker.sv
`default_nettype none
// Allocation ledger tracker. Records live in one single-port-read RAM of
// LEDGER_DEPTH entries; slots are handed out in order, so a fill count stands
// in for clearing the RAM after reset and the block is ready right away.
// Snapshot, ignored requests and allocate while the ledger still has unused
// slots go from idle straight to the finish state. Free, report and allocate
// on a full ledger first walk the used slots through the RAM read port, one
// entry a cycle. One item is in work at a time; the result sits in an output
// register so the next beat can be taken while it waits.
module allocation_ledger_tracker #(
  parameter int unsigned LEDGER_DEPTH = alt_pkg::LEDGER_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_data_i,      // tracking_enabled
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[1:0], address[49:2], alloc_size[81:50], zero fill
  input  wire logic [87:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[2:0], first_overflow[3], record_seq[35:4], record_size[67:36],
  // live_count[78:68], leaks_since_mark[89:79], leaked_bytes_since_mark[137:90],
  // current_bytes[185:138], peak_bytes[233:186], net_balance[265:234],
  // double_free_total[296:266], wild_free_total[327:297]
  output logic [327:0]      m_axis_tdata
);
  import alt_pkg::*;

  localparam int unsigned IW = (LEDGER_DEPTH > 1) ? $clog2(LEDGER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LEDGER_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(LEDGER_DEPTH);
  localparam logic [30:0] MAX31 = {31{1'b1}};
  localparam logic [47:0] MAX48 = {48{1'b1}};

  function automatic logic [30:0] inc31(input logic [30:0] v);
    return (v == MAX31) ? v : v + 31'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [10:0] sat11(input logic [CW-1:0] v);
    return (32'(v) > 32'd2047) ? 11'h7FF : 11'(v);
  endfunction

  state_e state_q, state_d;
  logic   en_q;
  cmd_e   cmd_q, cmd_d;
  logic [47:0] addr_q, addr_d;
  logic [31:0] size_q, size_d;

  logic [CW-1:0] fill_q, fill_d, act_q, act_d;
  logic [31:0] seq_q, seq_d, mseq_q, mseq_d;
  logic [30:0] malloc_q, malloc_d, mfree_q, mfree_d;
  logic [30:0] alloc_q, alloc_d, free_q, free_d, dbl_q, dbl_d, wild_q, wild_d;
  logic        ovf_q, ovf_d;
  logic [47:0] held_q, held_d, peak_q, peak_d;

  logic [CW-1:0] rcnt_q, rcnt_d, leaks_q, leaks_d;
  logic          rvld_q, rvld_d;
  logic [IW-1:0] ridx_q, ridx_d, hidx_q, hidx_d;
  logic          found_q, found_d, dfound_q, dfound_d;
  logic [31:0]   hsize_q, hsize_d, hseq_q, hseq_d, dseq_q, dseq_d, dsize_q, dsize_d;
  logic [47:0]   lbytes_q, lbytes_d;

  logic          mvld_q, mvld_d;
  logic [327:0]  mdata_q, mdata_d;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata, rdata;
  logic          issue, in_acc, ignore_in, ignore_q, scan_need, commit;
  cmd_e          in_cmd;

  alt_ledger_ram #(.DEPTH(LEDGER_DEPTH), .AW(IW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rcnt_q[IW-1:0]),
    .rdata_o (rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = mdata_q;

  assign in_cmd    = cmd_e'(s_axis_tdata[1:0]);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign ignore_in = (in_cmd == CMD_ALLOC || in_cmd == CMD_FREE) &&
                     (!en_q || s_axis_tdata[49:2] == 48'd0);
  assign ignore_q  = (cmd_q == CMD_ALLOC || cmd_q == CMD_FREE) &&
                     (!en_q || addr_q == 48'd0);
  assign scan_need = !ignore_in && (fill_q != '0) &&
                     ((in_cmd == CMD_ALLOC && fill_q == FULL) ||
                      in_cmd == CMD_FREE || in_cmd == CMD_REPORT);
  assign issue     = (state_q == S_SCAN) && (rcnt_q < fill_q);
  assign commit    = (state_q == S_FINISH) && (!mvld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = scan_need ? S_SCAN : S_FINISH;
      S_SCAN:   if (!issue && !rvld_q) state_d = S_FINISH;
      S_FINISH: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    logic [31:0] nseq;
    logic [32:0] net;
    status_e     st;
    logic        fo;
    logic [31:0] rseq, rsize;
    logic [CW-1:0] lk;
    logic [47:0] lb;

    cmd_d = cmd_q; addr_d = addr_q; size_d = size_q;
    fill_d = fill_q; act_d = act_q; seq_d = seq_q; mseq_d = mseq_q;
    malloc_d = malloc_q; mfree_d = mfree_q; alloc_d = alloc_q; free_d = free_q;
    dbl_d = dbl_q; wild_d = wild_q; ovf_d = ovf_q; held_d = held_q; peak_d = peak_q;
    rcnt_d = rcnt_q; leaks_d = leaks_q; rvld_d = 1'b0; ridx_d = rcnt_q[IW-1:0];
    hidx_d = hidx_q; found_d = found_q; dfound_d = dfound_q;
    hsize_d = hsize_q; hseq_d = hseq_q; dseq_d = dseq_q; dsize_d = dsize_q;
    lbytes_d = lbytes_q;
    mvld_d = mvld_q && !m_axis_tready;
    mdata_d = mdata_q;
    we = 1'b0; waddr = hidx_q; wdata = '0;
    nseq = '0; st = ST_OK; fo = 1'b0; rseq = '0; rsize = '0; lk = '0; lb = '0; net = '0;

    if (in_acc) begin
      cmd_d = in_cmd;
      addr_d = s_axis_tdata[49:2];
      size_d = s_axis_tdata[81:50];
      rcnt_d = '0; found_d = 1'b0; dfound_d = 1'b0; leaks_d = '0; lbytes_d = '0;
    end

    if (state_q == S_SCAN) begin
      rvld_d = issue;
      if (issue) rcnt_d = rcnt_q + CW'(1);
      if (rvld_q) begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (!found_q && !rdata.active) begin
              found_d = 1'b1; hidx_d = ridx_q;
            end
          end
          CMD_FREE: begin
            if (rdata.addr == addr_q) begin
              if (!found_q && rdata.active) begin
                found_d = 1'b1; hidx_d = ridx_q;
                hsize_d = rdata.size; hseq_d = rdata.seq;
              end
              if (!dfound_q && !rdata.active) begin
                dfound_d = 1'b1; dseq_d = rdata.seq; dsize_d = rdata.size;
              end
            end
          end
          CMD_REPORT: begin
            if (rdata.active && rdata.seq > mseq_q) begin
              leaks_d = leaks_q + CW'(1);
              lbytes_d = add48(lbytes_q, {16'd0, rdata.size});
            end
          end
          default: ;
        endcase
      end
    end

    if (commit) begin
      if (ignore_q) begin
        st = ST_IGNORED;
      end else begin
        case (cmd_q)
          CMD_ALLOC: begin
            alloc_d = inc31(alloc_q);
            nseq = (seq_q == 32'hFFFF_FFFF) ? seq_q : seq_q + 32'd1;
            seq_d = nseq;
            if (fill_q != FULL || found_q) begin
              we = 1'b1;
              waddr = (fill_q != FULL) ? fill_q[IW-1:0] : hidx_q;
              wdata = '{active: 1'b1, seq: nseq, size: size_q, addr: addr_q};
              if (fill_q != FULL) fill_d = fill_q + CW'(1);
              act_d = act_q + CW'(1);
              held_d = add48(held_q, {16'd0, size_q});
              if (held_d > peak_q) peak_d = held_d;
              rseq = nseq;
            end else begin
              st = ST_FULL;
              fo = !ovf_q;
              ovf_d = 1'b1;
            end
          end
          CMD_FREE: begin
            free_d = inc31(free_q);
            if (found_q) begin
              we = 1'b1;
              waddr = hidx_q;
              wdata = '{active: 1'b0, seq: hseq_q, size: hsize_q, addr: addr_q};
              held_d = (held_q >= {16'd0, hsize_q}) ? held_q - {16'd0, hsize_q} : '0;
              if (act_q != '0) act_d = act_q - CW'(1);
            end else if (dfound_q) begin
              dbl_d = inc31(dbl_q);
              st = ST_DOUBLE; rseq = dseq_q; rsize = dsize_q;
            end else begin
              wild_d = inc31(wild_q);
              st = ST_WILD;
            end
          end
          CMD_SNAP: begin
            mseq_d = seq_q; malloc_d = alloc_q; mfree_d = free_q;
          end
          CMD_REPORT: begin
            lk = leaks_q; lb = lbytes_q;
          end
          default: ;
        endcase
      end
      net = ({2'b0, alloc_d} - {2'b0, malloc_d}) - ({2'b0, free_d} - {2'b0, mfree_d});
      mvld_d = 1'b1;
      mdata_d = {wild_d, dbl_d, net[31:0], peak_d, held_d, lb, sat11(lk),
                 sat11(act_d), rsize, rseq, fo, st};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; en_q <= 1'b0;
      fill_q <= '0; act_q <= '0; seq_q <= '0; mseq_q <= '0;
      malloc_q <= '0; mfree_q <= '0; alloc_q <= '0; free_q <= '0;
      dbl_q <= '0; wild_q <= '0; ovf_q <= 1'b0; held_q <= '0; peak_q <= '0;
      rcnt_q <= '0; rvld_q <= 1'b0; mvld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) en_q <= cfg_data_i;
      fill_q <= fill_d; act_q <= act_d; seq_q <= seq_d; mseq_q <= mseq_d;
      malloc_q <= malloc_d; mfree_q <= mfree_d; alloc_q <= alloc_d; free_q <= free_d;
      dbl_q <= dbl_d; wild_q <= wild_d; ovf_q <= ovf_d; held_q <= held_d; peak_q <= peak_d;
      rcnt_q <= rcnt_d; rvld_q <= rvld_d; mvld_q <= mvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; addr_q <= addr_d; size_q <= size_d;
    leaks_q <= leaks_d; ridx_q <= ridx_d; hidx_q <= hidx_d;
    found_q <= found_d; dfound_q <= dfound_d;
    hsize_q <= hsize_d; hseq_q <= hseq_d; dseq_q <= dseq_d; dsize_q <= dsize_d;
    lbytes_q <= lbytes_d; mdata_q <= mdata_d;
  end

`ifndef SYNTHESIS
  // ram is written only once the walk is over
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && state_q == S_SCAN)) else $error("ledger write during scan");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL) else $error("fill count past depth");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q <= fill_q) else $error("more live records than used slots");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> state_q == S_IDLE && mvld_q) else $error("result not loaded");
`endif

endmodule
`default_nettype wire

>>> tb/allocation_ledger_checker.sv
`timescale 1ns / 1ps
module allocation_ledger_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic         cfg_data_i,
  input  wire logic         in_valid_i,
  input  wire logic         in_ready_i,
  input  wire logic [87:0]  in_data_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_ready_i,
  input  wire logic [327:0] out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import alt_pkg::*;
  localparam int DEPTH = 1024;
  localparam logic [47:0] MAX48 = '1;
  localparam logic [30:0] MAX31 = '1;

  logic [47:0] led_addr [DEPTH];
  logic [31:0] led_size [DEPTH];
  logic [31:0] led_seq  [DEPTH];
  logic        led_act  [DEPTH];
  logic [10:0] n_active;
  logic [31:0] seq_no, mark_seq;
  logic [30:0] mark_allocs, mark_frees, allocs, frees, dbl_cnt, wild_cnt;
  logic        ovf_seen, tracking;
  logic [47:0] held, peak;
  logic [327:0] outcome_q[$];

  assign pending_o = outcome_q.size();

  function automatic logic [30:0] bump31(logic [30:0] v);
    return (v == MAX31) ? v : v + 31'd1;
  endfunction

  task automatic apply_command(input logic [87:0] d);
    cmd_e        cmd;
    logic [47:0] a;
    logic [31:0] sz;
    status_e     st;
    logic        fo;
    logic [31:0] rseq, rsize;
    logic [10:0] leaks;
    logic [48:0] lb;
    logic [31:0] net;
    int          slot;
    cmd = cmd_e'(d[1:0]);
    a = d[49:2];
    sz = d[81:50];
    st = ST_OK; fo = 0; rseq = 0; rsize = 0; leaks = 0; lb = 0; slot = -1;
    if ((cmd == CMD_ALLOC || cmd == CMD_FREE) && (!tracking || a == 0)) begin
      st = ST_IGNORED;
    end else if (cmd == CMD_ALLOC) begin
      allocs = bump31(allocs);
      if (seq_no != '1) seq_no++;
      for (int i = 0; i < DEPTH && slot < 0; i++)
        if (!led_act[i] && led_seq[i] == 0) slot = i;
      for (int i = 0; i < DEPTH && slot < 0; i++)
        if (!led_act[i]) slot = i;
      if (slot < 0) begin
        st = ST_FULL;
        if (!ovf_seen) begin
          fo = 1;
          ovf_seen = 1;
        end
      end else begin
        led_addr[slot] = a; led_size[slot] = sz;
        led_seq[slot] = seq_no; led_act[slot] = 1;
        n_active++;
        held = ({1'b0, held} + sz > {1'b0, MAX48}) ? MAX48 : held + sz;
        if (held > peak) peak = held;
        rseq = seq_no;
      end
    end else if (cmd == CMD_FREE) begin
      frees = bump31(frees);
      for (int i = 0; i < DEPTH && slot < 0; i++)
        if (led_act[i] && led_addr[i] == a) slot = i;
      if (slot >= 0) begin
        held = (held >= led_size[slot]) ? held - led_size[slot] : 0;
        led_act[slot] = 0;
        if (n_active > 0) n_active--;
      end else begin
        for (int i = 0; i < DEPTH && slot < 0; i++)
          if (!led_act[i] && led_seq[i] > 0 && led_addr[i] == a) slot = i;
        if (slot >= 0) begin
          dbl_cnt = bump31(dbl_cnt);
          st = ST_DOUBLE;
          rseq = led_seq[slot];
          rsize = led_size[slot];
        end else begin
          wild_cnt = bump31(wild_cnt);
          st = ST_WILD;
        end
      end
    end else if (cmd == CMD_SNAP) begin
      mark_seq = seq_no; mark_allocs = allocs; mark_frees = frees;
    end else begin
      for (int i = 0; i < DEPTH; i++)
        if (led_act[i] && led_seq[i] > mark_seq) begin
          leaks++;
          lb = lb + led_size[i];
          if (lb > {1'b0, MAX48}) lb = {1'b0, MAX48};
        end
    end
    net = (32'(allocs) - 32'(mark_allocs)) - (32'(frees) - 32'(mark_frees));
    outcome_q.push_back({wild_cnt, dbl_cnt, net, peak, held, lb[47:0], leaks,
                         n_active, rsize, rseq, fo, st});
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        led_addr[i] = 0; led_size[i] = 0; led_seq[i] = 0; led_act[i] = 0;
      end
      n_active = 0; seq_no = 0; mark_seq = 0; mark_allocs = 0; mark_frees = 0;
      allocs = 0; frees = 0; dbl_cnt = 0; wild_cnt = 0; ovf_seen = 0;
      held = 0; peak = 0; tracking = 0;
      outcome_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) tracking = cfg_data_i;
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected result beat: actual %h", $time, out_data_i);
          fail_count_o++;
        end else if (outcome_q[0] !== out_data_i) begin
          $display("%0t result mismatch: expected %h actual %h", $time,
                   outcome_q[0], out_data_i);
          fail_count_o++;
          void'(outcome_q.pop_front());
        end else begin
          void'(outcome_q.pop_front());
        end
      end
    end
  end
endmodule

>>> tb/allocation_ledger_tracker_test.sv
`timescale 1ns / 1ps
module allocation_ledger_tracker_test;
  import alt_pkg::*;

  logic         clk = 0, rst_n = 0;
  logic         cfg_valid = 0, cfg_data = 0, cfg_ready;
  logic         in_valid = 0, in_ready;
  logic [87:0]  in_data = 0;
  logic         out_valid, out_ready = 0;
  logic [327:0] out_data;
  int           fail_count, pending;
  bit           hold_off = 0;
  logic [47:0]  addr_pool [16];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  allocation_ledger_tracker DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready), .m_axis_tdata(out_data)
  );

  allocation_ledger_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (($time / 2000) % 3 == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_beat(input cmd_e cmd, input logic [47:0] a, input logic [31:0] sz);
    in_data <= {6'b0, sz, a, cmd};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic write_tracking(input logic v);
    while (pending != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(input int n, input int pool_bits);
    int burst;
    cmd_e c;
    logic [47:0] a;
    logic [31:0] sz;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c = CMD_ALLOC;
        4, 5, 6:    c = CMD_FREE;
        7:          c = CMD_SNAP;
        default:    c = CMD_REPORT;
      endcase
      a = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) :
          addr_pool[$urandom_range(0, (1 << pool_bits) - 1)];
      if ($urandom_range(0, 29) == 0) a = 0;
      sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4096);
      send_beat(c, a, sz);
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(0, 12);
      end else burst--;
    end
    in_valid <= 0;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) addr_pool[i] = 48'({$urandom, $urandom}) | 48'h1;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // tracking off at reset: allocate and free are ignored
    send_beat(CMD_ALLOC, 48'h1000, 32'd16);
    send_beat(CMD_FREE, 48'h1000, 32'd0);
    send_beat(CMD_REPORT, 48'h0, 32'd0);
    in_valid <= 0;
    write_tracking(1);
    send_beat(CMD_ALLOC, '1, '1);
    send_beat(CMD_ALLOC, '1, '1);
    send_beat(CMD_ALLOC, 48'h1, 32'd0);
    send_beat(CMD_ALLOC, 48'h0, 32'd5);
    send_beat(CMD_SNAP, '1, '1);
    send_beat(CMD_ALLOC, 48'h2, 32'h8000_0000);
    send_beat(CMD_REPORT, 48'h0, 32'd0);
    send_beat(CMD_FREE, '1, 32'd0);
    send_beat(CMD_FREE, '1, 32'd0);
    send_beat(CMD_FREE, '1, 32'd0);
    send_beat(CMD_FREE, 48'h1234, 32'd0);
    send_beat(CMD_FREE, 48'h0, 32'd0);
    send_beat(CMD_ALLOC, 48'h3, 32'd9);
    send_beat(CMD_REPORT, 48'h0, 32'd0);
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      random_phase(10, 2);
    join
    @(negedge clk);
    random_phase(120, 3);
    write_tracking(0);
    random_phase(20, 3);
    write_tracking(1);
    random_phase(110, 4);
    while (pending != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

>>> allocation_ledger_tracker.f
sv/alt_pkg.sv
sv/alt_ledger_ram.sv
sv/allocation_ledger_tracker.sv
tb/allocation_ledger_checker.sv
tb/allocation_ledger_tracker_test.sv
